// ===== rtl/button_debounce_click_classifier_top_assert.svh =====
// Assertion macros for the click classifier top level.
// Each macro expects clk and rst in the scope where it is used.
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication.
`define BDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdc_pkg.sv =====
package bdc_pkg;

  localparam int NUM_KEYS        = 6;
  localparam int TICK_WIDTH      = 32;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int EV_WIDTH        = 2;

  // Reset values of the configuration registers
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = CFG_WIDTH'(10);
  localparam logic [CFG_WIDTH-1:0] LONG_RESET     = CFG_WIDTH'(1000);
  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET   = CFG_WIDTH'(300);
  localparam logic [CFG_WIDTH-1:0] REPEAT_RESET   = CFG_WIDTH'(100);

  typedef logic [TICK_WIDTH-1:0] tick_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DEBOUNCE = 3'd0,
    REG_ACTIVE   = 3'd1,
    REG_LONG     = 3'd2,
    REG_WINDOW   = 3'd3,
    REG_REPEAT   = 3'd4
  } reg_index_t;

  // Classifier phase per key
  typedef enum logic [2:0] {
    PH_RELEASED = 3'd0,
    PH_SHORT    = 3'd1,
    PH_WAIT     = 3'd2,
    PH_DOUBLE   = 3'd3,
    PH_LONG     = 3'd4
  } phase_t;

  // Event code per key
  typedef enum logic [EV_WIDTH-1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  // Timing settings shared by all classifier lanes
  typedef struct packed {
    logic [CFG_WIDTH-1:0] long_press_ticks;
    logic [CFG_WIDTH-1:0] double_click_window_ticks;
    logic [CFG_WIDTH-1:0] repeat_interval_ticks;
  } class_cfg_t;

endpackage

// ===== rtl/bdc_debounce.sv =====
module bdc_debounce (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  bdc_pkg::tick_t                 now,
  input  logic                           raw,
  input  logic                           active,
  input  logic [bdc_pkg::CFG_WIDTH-1:0]  debounce_ticks,
  output logic                           filtered
);

  logic           last_match;
  bdc_pkg::tick_t window_start;

  bdc_pkg::tick_t held;
  bdc_pkg::tick_t db_wide;
  logic           match;
  logic           filtered_next;
  bdc_pkg::tick_t window_start_next;

  assign held    = now - window_start;
  assign db_wide = bdc_pkg::TICK_WIDTH'(debounce_ticks);
  assign match   = (raw == active);

  // Window filter with credited restart
  always_comb begin
    filtered_next     = filtered;
    window_start_next = window_start;
    if (match == last_match) begin
      if (held > db_wide) filtered_next = match;
    end else if (held >= db_wide) begin
      window_start_next = now;
    end else begin
      window_start_next = now - (db_wide - held);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_match   <= 1'b0;
      filtered     <= 1'b0;
      window_start <= '0;
    end else if (en) begin
      last_match   <= match;
      filtered     <= filtered_next;
      window_start <= window_start_next;
    end
  end

endmodule

// ===== rtl/bdc_classify.sv =====
module bdc_classify (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  bdc_pkg::tick_t       now,
  input  logic                 down,
  input  bdc_pkg::class_cfg_t  cfg,
  output bdc_pkg::event_t      ev
);

  bdc_pkg::phase_t              phase;
  bdc_pkg::tick_t               stamp;
  logic [bdc_pkg::CFG_WIDTH-1:0] repeat_count;

  bdc_pkg::phase_t               phase_next;
  bdc_pkg::tick_t                stamp_next;
  logic [bdc_pkg::CFG_WIDTH-1:0] repeat_count_next;

  bdc_pkg::tick_t             since;
  logic                       long_hit;
  logic                       in_window;
  logic [bdc_pkg::CFG_WIDTH:0] rc_inc;
  logic                       repeat_hit;

  assign since      = now - stamp;
  assign long_hit   = since > bdc_pkg::TICK_WIDTH'(cfg.long_press_ticks);
  assign in_window  = since < bdc_pkg::TICK_WIDTH'(cfg.double_click_window_ticks);
  assign rc_inc     = {1'b0, repeat_count} + 1'b1;
  assign repeat_hit = rc_inc >= {1'b0, cfg.repeat_interval_ticks};

  // Next phase, stamp and repeat count
  always_comb begin
    phase_next        = phase;
    stamp_next        = stamp;
    repeat_count_next = repeat_count;
    case (phase)
      bdc_pkg::PH_RELEASED: begin
        if (down) begin
          stamp_next = now;
          phase_next = bdc_pkg::PH_SHORT;
        end
      end
      bdc_pkg::PH_SHORT: begin
        if (!down) begin
          phase_next = bdc_pkg::PH_WAIT;
        end else if (long_hit) begin
          stamp_next        = now;
          repeat_count_next = '0;
          phase_next        = bdc_pkg::PH_LONG;
        end
      end
      bdc_pkg::PH_WAIT: begin
        if (!in_window) phase_next = bdc_pkg::PH_RELEASED;
        else if (down)  phase_next = bdc_pkg::PH_DOUBLE;
      end
      bdc_pkg::PH_DOUBLE: begin
        if (!down) phase_next = bdc_pkg::PH_RELEASED;
      end
      bdc_pkg::PH_LONG: begin
        if (!down) begin
          phase_next = bdc_pkg::PH_RELEASED;
        end else if (repeat_hit) begin
          repeat_count_next = '0;
        end else begin
          repeat_count_next = rc_inc[bdc_pkg::CFG_WIDTH-1:0];
        end
      end
      default: phase_next = phase;
    endcase
  end

  // Event for this tick
  always_comb begin
    ev = bdc_pkg::EV_NONE;
    case (phase)
      bdc_pkg::PH_SHORT: if (down && long_hit) ev = bdc_pkg::EV_LONG;
      bdc_pkg::PH_WAIT: begin
        if (!in_window) ev = bdc_pkg::EV_SINGLE;
        else if (down)  ev = bdc_pkg::EV_DOUBLE;
      end
      bdc_pkg::PH_LONG: if (down && repeat_hit) ev = bdc_pkg::EV_LONG;
      default: ev = bdc_pkg::EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= bdc_pkg::PH_RELEASED;
      stamp        <= '0;
      repeat_count <= '0;
    end else if (en) begin
      phase        <= phase_next;
      stamp        <= stamp_next;
      repeat_count <= repeat_count_next;
    end
  end

endmodule

// ===== rtl/button_debounce_click_classifier_top.sv =====
// Key debounce and click classifier.
// Input channel (in_valid / in_stall): one transfer per timer tick, carrying
// the raw level of every key in raw_levels.
// Output channel (out_valid / out_stall): one transfer per tick with the
// debounced levels and a two-bit event per key (none, single, double, long).
// Configuration port (cfg_valid / cfg_ready): cfg_ready is always high; write
// only while no tick is in flight. Unknown indexes are dropped.
// Pipeline: stage one runs the per-key debounce lanes and the tick counter,
// stage two runs the per-key classifier lanes and merges their results into
// the output register. An input transfer is registered in stage one, and its
// stage-two transfer loads the output register and raises out_valid;
// throughput is one tick per cycle while the receiver does not stall.
// Reset (rst, synchronous): tick counter, filters and classifiers clear,
// configuration returns to its defaults, both pipeline stages empty.
// When the receiver stalls, the result holds in the output register, one more
// tick is taken into stage one, and then in_stall rises until space frees.
`include "button_debounce_click_classifier_top_assert.svh"

module button_debounce_click_classifier_top (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [bdc_pkg::NUM_KEYS-1:0]                raw_levels,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [bdc_pkg::NUM_KEYS-1:0]                filtered_levels,
  output logic [bdc_pkg::EV_WIDTH*bdc_pkg::NUM_KEYS-1:0] key_events,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [bdc_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
  input  logic [bdc_pkg::CFG_WIDTH-1:0]               cfg_data
);

  // Configuration registers
  logic [bdc_pkg::CFG_WIDTH-1:0] debounce_ticks;
  logic [bdc_pkg::NUM_KEYS-1:0]  active_levels;
  bdc_pkg::class_cfg_t           class_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks                      <= bdc_pkg::DEBOUNCE_RESET;
      active_levels                       <= '0;
      class_cfg.long_press_ticks          <= bdc_pkg::LONG_RESET;
      class_cfg.double_click_window_ticks <= bdc_pkg::WINDOW_RESET;
      class_cfg.repeat_interval_ticks     <= bdc_pkg::REPEAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bdc_pkg::REG_DEBOUNCE: debounce_ticks <= cfg_data;
        bdc_pkg::REG_ACTIVE:   active_levels  <= cfg_data[bdc_pkg::NUM_KEYS-1:0];
        bdc_pkg::REG_LONG:     class_cfg.long_press_ticks <= cfg_data;
        bdc_pkg::REG_WINDOW:   class_cfg.double_click_window_ticks <= cfg_data;
        bdc_pkg::REG_REPEAT:   class_cfg.repeat_interval_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic           stage1_valid;
  logic           out_free;
  logic           s1_fire;
  logic           s2_fire;
  bdc_pkg::tick_t tick_count;
  bdc_pkg::tick_t stage1_tick;

  assign out_free = !out_valid || !out_stall;
  assign s2_fire  = stage1_valid && out_free;
  assign in_stall = stage1_valid && !s2_fire;
  assign s1_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      out_valid    <= 1'b0;
      tick_count   <= '0;
    end else begin
      if (s1_fire)       stage1_valid <= 1'b1;
      else if (s2_fire)  stage1_valid <= 1'b0;
      if (s2_fire)       out_valid <= 1'b1;
      else if (out_free) out_valid <= 1'b0;
      if (s1_fire)       tick_count <= tick_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) stage1_tick <= tick_count;
  end

  // Key lanes
  logic [bdc_pkg::NUM_KEYS-1:0] filtered;
  bdc_pkg::event_t              lane_ev [bdc_pkg::NUM_KEYS];

  for (genvar k = 0; k < bdc_pkg::NUM_KEYS; k++) begin : g_lane
    bdc_debounce u_debounce (
      .clk            (clk),
      .rst            (rst),
      .en             (s1_fire),
      .now            (tick_count),
      .raw            (raw_levels[k]),
      .active         (active_levels[k]),
      .debounce_ticks (debounce_ticks),
      .filtered       (filtered[k])
    );

    bdc_classify u_classify (
      .clk  (clk),
      .rst  (rst),
      .en   (s2_fire),
      .now  (stage1_tick),
      .down (filtered[k]),
      .cfg  (class_cfg),
      .ev   (lane_ev[k])
    );
  end

  // Merge lane results into the output register
  logic [bdc_pkg::EV_WIDTH*bdc_pkg::NUM_KEYS-1:0] events_merged;

  always_comb begin
    for (int k = 0; k < bdc_pkg::NUM_KEYS; k++) begin
      events_merged[k*bdc_pkg::EV_WIDTH +: bdc_pkg::EV_WIDTH] = lane_ev[k];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      filtered_levels <= filtered;
      key_events      <= events_merged;
    end
  end

  // Checks
  `BDC_ASSERT_NOW(a_stall_needs_item, !stage1_valid, !in_stall, "stall with empty stage one")
  `BDC_ASSERT_NEXT(a_result_lands, s2_fire, out_valid, "classified tick did not reach output")
  `BDC_ASSERT_NEXT(a_tick_advance, s1_fire, tick_count == $past(tick_count) + 1'b1, "tick stuck")
  `BDC_ASSERT_NEXT(a_stage1_holds, stage1_valid && !s2_fire, stage1_valid, "stage one item lost")

endmodule
